// ===== hdl/rvt_pkg.sv =====
package rvt_pkg;

  // Command table depth and the widths that follow from it
  localparam int MAX_COMMANDS = 128;
  localparam int IDX_W        = $clog2(MAX_COMMANDS);
  localparam int CNT_W        = (IDX_W + 1 > 8) ? IDX_W + 1 : 8;

  // Input item kinds
  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_ENC  = 2'd1;
  localparam logic [1:0] KIND_DEC  = 2'd2;

  // Configuration register indexes
  localparam logic REG_SIZE  = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  // Operand size codes
  localparam logic [1:0] SZ_BYTE  = 2'd0;
  localparam logic [1:0] SZ_WORD  = 2'd1;
  localparam logic [1:0] SZ_DWORD = 2'd2;
  localparam logic [1:0] SZ_QWORD = 2'd3;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_XOR   = 3'd2,
    OP_NOT   = 3'd3,
    OP_NEG   = 3'd4,
    OP_BSWAP = 3'd5,
    OP_ROL   = 3'd6,
    OP_ROR   = 3'd7
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [63:0] operand;
  } cmd_t;

  // Per-cell control: load from the input, rotate toward cell 0, rotate toward the last cell
  typedef struct packed {
    logic load;
    logic fwd;
    logic bwd;
  } cell_ctl_t;

  function automatic logic [63:0] size_mask(input logic [1:0] sz);
    logic [63:0] m;
    unique case (sz)
      SZ_BYTE:  m = 64'h0000_0000_0000_00FF;
      SZ_WORD:  m = 64'h0000_0000_0000_FFFF;
      SZ_DWORD: m = 64'h0000_0000_FFFF_FFFF;
      default:  m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

// ===== hdl/rvt_cell.sv =====
module rvt_cell import rvt_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  cmd_t      load_cmd,
  input  cmd_t      next_cmd,
  input  cmd_t      prev_cmd,
  output cmd_t      cmd_q
);

  cmd_t cmd_r;
  cmd_t cmd_nxt;

  // Load from the input beat, or take the neighbor's command as the ring turns
  always_comb begin
    priority if (ctl.load) begin
      cmd_nxt = load_cmd;
    end else if (ctl.fwd) begin
      cmd_nxt = next_cmd;
    end else if (ctl.bwd) begin
      cmd_nxt = prev_cmd;
    end else begin
      cmd_nxt = cmd_r;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

  assign cmd_q = cmd_r;

endmodule

// ===== hdl/rvt_alu.sv =====
module rvt_alu import rvt_pkg::*; (
  input  cmd_t        cmd,
  input  logic        dec,
  input  logic [1:0]  size,
  input  logic [63:0] val_in,
  output logic [63:0] val_out
);

  op_t          op_eff;
  logic         left;
  logic [2:0]   k8;
  logic [3:0]   k16;
  logic [4:0]   k32;
  logic [5:0]   k64;
  logic [15:0]  d8;
  logic [31:0]  d16;
  logic [63:0]  d32;
  logic [127:0] d64;
  logic [63:0]  rot;
  logic [63:0]  swp;

  // Invert add/sub and rol/ror on the decrypt pass
  always_comb begin
    op_eff = cmd.op;
    if (dec) begin
      unique case (cmd.op)
        OP_ADD:  op_eff = OP_SUB;
        OP_SUB:  op_eff = OP_ADD;
        OP_ROL:  op_eff = OP_ROR;
        OP_ROR:  op_eff = OP_ROL;
        default: op_eff = cmd.op;
      endcase
    end
  end

  // Rotate right by k is rotate left by the negated amount modulo the width
  assign left = (op_eff == OP_ROL);
  assign k8   = left ? cmd.operand[2:0] : 3'd0 - cmd.operand[2:0];
  assign k16  = left ? cmd.operand[3:0] : 4'd0 - cmd.operand[3:0];
  assign k32  = left ? cmd.operand[4:0] : 5'd0 - cmd.operand[4:0];
  assign k64  = left ? cmd.operand[5:0] : 6'd0 - cmd.operand[5:0];

  assign d8  = {val_in[7:0], val_in[7:0]} << k8;
  assign d16 = {val_in[15:0], val_in[15:0]} << k16;
  assign d32 = {val_in[31:0], val_in[31:0]} << k32;
  assign d64 = {val_in, val_in} << k64;

  // Select rotate and byte swap at the current size, zero-extended (byte swap at byte size passes all 64 bits)
  always_comb begin
    unique case (size)
      SZ_BYTE: begin
        rot = {56'd0, d8[15:8]};
        swp = val_in;
      end
      SZ_WORD: begin
        rot = {48'd0, d16[31:16]};
        swp = {48'd0, val_in[7:0], val_in[15:8]};
      end
      SZ_DWORD: begin
        rot = {32'd0, d32[63:32]};
        swp = {32'd0, val_in[7:0], val_in[15:8], val_in[23:16], val_in[31:24]};
      end
      default: begin
        rot = d64[127:64];
        swp = {val_in[7:0], val_in[15:8], val_in[23:16], val_in[31:24],
               val_in[39:32], val_in[47:40], val_in[55:48], val_in[63:56]};
      end
    endcase
  end

  always_comb begin
    unique case (op_eff)
      OP_ADD:   val_out = val_in + cmd.operand;
      OP_SUB:   val_out = val_in - cmd.operand;
      OP_XOR:   val_out = val_in ^ cmd.operand;
      OP_NOT:   val_out = ~val_in;
      OP_NEG:   val_out = 64'd0 - val_in;
      OP_BSWAP: val_out = swp;
      default:  val_out = rot;
    endcase
  end

endmodule

// ===== hdl/reversible_value_transform_chain.sv =====
// Reversible value transform chain. Load items write one command into the table and
// return nothing. Encrypt and decrypt items run a pass over the whole table:
// the command table is a ring of cells that turns one place per cycle past a single transform unit,
// so one command is applied per cycle, and the ring always makes a full turn so it is back home
// for the next load. Commands at or beyond command_count pass the value through untouched.
// The finished value goes to an output register, so a new item is taken while a result waits;
// an item that finishes while the previous result is still unread holds until it is taken.
// Table entries never written read as garbage; there is no clearing pass after reset.
module reversible_value_transform_chain import rvt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [6:0]  in_slot,
  input  logic [2:0]  in_op_code,
  input  logic [63:0] in_operand,
  input  logic [63:0] in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_result,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_HOLD} state_t;

  state_t           state_r;
  logic [IDX_W-1:0] step_r;
  logic             dec_r;
  logic [63:0]      val_r;
  logic             out_valid_r;
  logic [63:0]      out_result_r;
  logic [1:0]       size_r;
  logic [7:0]       count_r;

  cmd_t             cmd_q [MAX_COMMANDS];
  cmd_t             load_cmd;
  cmd_t             head_cmd;
  logic             load_fire;
  logic             slot_ok;
  logic             run;
  logic [IDX_W-1:0] cur_idx;
  logic             active;
  logic             last_step;
  logic             out_free;
  logic             out_load;
  logic [63:0]      alu_out;
  logic [63:0]      val_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign load_fire = in_valid && in_ready && (in_kind == KIND_LOAD);
  assign slot_ok   = (CNT_W'(in_slot) < CNT_W'(MAX_COMMANDS));
  assign run       = (state_r == ST_RUN);
  assign out_free  = !out_valid_r || out_ready;

  // Truncate the operand to the current size on load
  assign load_cmd.op      = op_t'(in_op_code);
  assign load_cmd.operand = in_operand & size_mask(size_r);

  // Ring of command cells
  for (genvar i = 0; i < MAX_COMMANDS; i++) begin : g_cell
    cell_ctl_t ctl;
    assign ctl.load = load_fire && slot_ok && (CNT_W'(in_slot) == CNT_W'(i));
    assign ctl.fwd  = run && !dec_r;
    assign ctl.bwd  = run && dec_r;

    rvt_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .load_cmd (load_cmd),
      .next_cmd (cmd_q[(i + 1) % MAX_COMMANDS]),
      .prev_cmd (cmd_q[(i + MAX_COMMANDS - 1) % MAX_COMMANDS]),
      .cmd_q    (cmd_q[i])
    );
  end

  // Encrypt reads the head cell going up, decrypt reads the tail cell going down
  assign head_cmd  = dec_r ? cmd_q[MAX_COMMANDS-1] : cmd_q[0];
  assign cur_idx   = dec_r ? (IDX_W'(MAX_COMMANDS - 1) - step_r) : step_r;
  assign active    = (CNT_W'(cur_idx) < CNT_W'(count_r));
  assign last_step = (step_r == IDX_W'(MAX_COMMANDS - 1));

  rvt_alu u_alu (
    .cmd     (head_cmd),
    .dec     (dec_r),
    .size    (size_r),
    .val_in  (val_r),
    .val_out (alu_out)
  );

  // Skip commands past the programmed count
  assign val_nxt = active ? alu_out : val_r;

  // Fill the output register at the end of a pass or from the hold state
  assign out_load = out_free && ((run && last_step) || (state_r == ST_HOLD));

  // Sequencer, configuration and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      size_r      <= SZ_BYTE;
      count_r     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SIZE:  size_r  <= cfg_wdata[1:0];
          REG_COUNT: count_r <= cfg_wdata;
        endcase
      end

      // Raise valid on a new result, drop it once taken
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid && (in_kind == KIND_ENC || in_kind == KIND_DEC)) begin
            state_r <= ST_RUN;
            dec_r   <= (in_kind == KIND_DEC);
            val_r   <= in_data;
            step_r  <= '0;
          end
        end
        ST_RUN: begin
          val_r  <= val_nxt;
          step_r <= last_step ? '0 : step_r + IDX_W'(1);
          if (last_step) begin
            if (out_free) begin
              out_result_r <= val_nxt;
              state_r      <= ST_IDLE;
            end else begin
              state_r <= ST_HOLD;
            end
          end
        end
        default: begin
          // Hold the finished value until the output register frees up
          if (out_free) begin
            out_result_r <= val_r;
            state_r      <= ST_IDLE;
          end
        end
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  // The step counter only moves during a pass
  a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_RUN |-> step_r == '0)
    else $error("step counter not at zero outside a pass");

  // A finished value only waits when the output register is occupied
  a_hold_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_HOLD |-> out_valid_r)
    else $error("holding a result while the output register is empty");

  // The last step of a pass either delivers or holds, never starts another pass
  a_pass_end: assert property (@(posedge clk) disable iff (!rst_n)
    run && last_step |=> state_r == ST_IDLE || state_r == ST_HOLD)
    else $error("pass did not end after the final command");

  // No input beat is taken while a pass is in flight
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    run |-> !in_ready)
    else $error("input ready during a pass");

endmodule

// ===== bench/tb.sv =====
module tb;
  import rvt_pkg::*;

  localparam int          ITEMS         = 550;
  localparam int          SETTLE_CYCLES = 140;
  localparam int          STALL_LIMIT   = 1500;
  localparam logic [1:0]  KIND_NONE     = 2'd3;
  localparam logic [63:0] ONES          = '1;
  localparam logic [63:0] TOP_BIT       = 64'h8000_0000_0000_0000;

  typedef enum logic {ROW_BEAT, ROW_REG} row_act_t;

  // One line of the directed script: either a beat or a register write (value in data)
  typedef struct packed {
    row_act_t    act;
    logic        reg_idx;
    logic [1:0]  kind;
    logic [6:0]  slot;
    op_t         op;
    logic [63:0] operand;
    logic [63:0] data;
    logic        pin;
    logic [63:0] want;
  } row_t;

  typedef struct {
    logic [63:0] value;
    logic        pinned;
    logic [63:0] pinned_value;
  } result_exp_t;

  localparam int NROWS = 31;
  localparam row_t SCRIPT [NROWS] = '{
    '{ROW_REG,  REG_SIZE,  KIND_LOAD, 7'd0, OP_ADD,   64'd0, 64'(SZ_QWORD), 1'b0, 64'd0},
    '{ROW_BEAT, REG_SIZE,  KIND_ENC,  7'd0, OP_ADD,   64'd0, ONES,          1'b1, ONES},
    '{ROW_BEAT, REG_SIZE,  KIND_DEC,  7'd0, OP_ADD,   64'd0, 64'd0,         1'b1, 64'd0},
    '{ROW_BEAT, REG_SIZE,  KIND_NONE, 7'd0, OP_ADD,   ONES,  64'h5A5A_5A5A_5A5A_5A5A, 1'b0, 64'd0},
    '{ROW_BEAT, REG_SIZE,  KIND_LOAD, 7'd0, OP_NOT,   64'd0, 64'd0,         1'b0, 64'd0},
    '{ROW_REG,  REG_COUNT, KIND_LOAD, 7'd0, OP_ADD,   64'd0, 64'd1,         1'b0, 64'd0},
    '{ROW_BEAT, REG_SIZE,  KIND_ENC,  7'd0, OP_ADD,   64'd0, 64'd0,         1'b1, ONES},
    '{ROW_BEAT, REG_SIZE,  KIND_DEC,  7'd0, OP_ADD,   64'd0, 64'h1234,
      1'b1, 64'hFFFF_FFFF_FFFF_EDCB},
    '{ROW_BEAT, REG_SIZE,  KIND_LOAD, 7'd0, OP_ADD,   ONES,  64'd0,         1'b0, 64'd0},
    '{ROW_BEAT, REG_SIZE,  KIND_ENC,  7'd0, OP_ADD,   64'd0, 64'd1,         1'b1, 64'd0},
    '{ROW_BEAT, REG_SIZE,  KIND_DEC,  7'd0, OP_ADD,   64'd0, 64'd0,         1'b1, 64'd1},
    '{ROW_BEAT, REG_SIZE,  KIND_LOAD, 7'd1, OP_SUB,   64'd1, 64'd0,         1'b0, 64'd0},
    '{ROW_BEAT, REG_SIZE,  KIND_LOAD, 7'd2, OP_XOR,   64'hA5A5_A5A5_A5A5_A5A5, 64'd0,
      1'b0, 64'd0},
    '{ROW_BEAT, REG_SIZE,  KIND_LOAD, 7'd3, OP_NEG,   64'd0, 64'd0,         1'b0, 64'd0},
    '{ROW_BEAT, REG_SIZE,  KIND_LOAD, 7'd4, OP_BSWAP, 64'd0, 64'd0,         1'b0, 64'd0},
    '{ROW_BEAT, REG_SIZE,  KIND_LOAD, 7'd5, OP_ROL,   64'd65, 64'd0,        1'b0, 64'd0},
    '{ROW_BEAT, REG_SIZE,  KIND_LOAD, 7'd6, OP_ROR,   64'd0, 64'd0,         1'b0, 64'd0},
    '{ROW_BEAT, REG_SIZE,  KIND_LOAD, 7'd7, OP_ROR,   64'h3F, 64'd0,        1'b0, 64'd0},
    '{ROW_REG,  REG_COUNT, KIND_LOAD, 7'd0, OP_ADD,   64'd0, 64'd8,         1'b0, 64'd0},
    '{ROW_BEAT, REG_SIZE,  KIND_ENC,  7'd0, OP_ADD,   64'd0, 64'h0123_4567_89AB_CDEF,
      1'b0, 64'd0},
    '{ROW_BEAT, REG_SIZE,  KIND_DEC,  7'd0, OP_ADD,   64'd0, 64'h0123_4567_89AB_CDEF,
      1'b0, 64'd0},
    '{ROW_REG,  REG_SIZE,  KIND_LOAD, 7'd0, OP_ADD,   64'd0, 64'(SZ_BYTE),  1'b0, 64'd0},
    '{ROW_BEAT, REG_SIZE,  KIND_ENC,  7'd0, OP_ADD,   64'd0, 64'hFEDC_BA98_7654_3210,
      1'b0, 64'd0},
    '{ROW_BEAT, REG_SIZE,  KIND_DEC,  7'd0, OP_ADD,   64'd0, TOP_BIT,       1'b0, 64'd0},
    '{ROW_BEAT, REG_SIZE,  KIND_LOAD, 7'd6, OP_ROR,   64'h1FF, 64'd0,       1'b0, 64'd0},
    '{ROW_BEAT, REG_SIZE,  KIND_LOAD, 7'd1, OP_SUB,   ONES,  64'd0,         1'b0, 64'd0},
    '{ROW_BEAT, REG_SIZE,  KIND_ENC,  7'd0, OP_ADD,   64'd0, 64'd0,         1'b0, 64'd0},
    '{ROW_REG,  REG_SIZE,  KIND_LOAD, 7'd0, OP_ADD,   64'd0, 64'(SZ_WORD),  1'b0, 64'd0},
    '{ROW_BEAT, REG_SIZE,  KIND_ENC,  7'd0, OP_ADD,   64'd0, 64'h0123_4567_89AB_CDEF,
      1'b0, 64'd0},
    '{ROW_REG,  REG_SIZE,  KIND_LOAD, 7'd0, OP_ADD,   64'd0, 64'(SZ_DWORD), 1'b0, 64'd0},
    '{ROW_BEAT, REG_SIZE,  KIND_DEC,  7'd0, OP_ADD,   64'd0, 64'h0123_4567_89AB_CDEF,
      1'b0, 64'd0}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_kind;
  logic [6:0]  in_slot;
  logic [2:0]  in_op_code;
  logic [63:0] in_operand;
  logic [63:0] in_data;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_result;
  logic        cfg_we;
  logic        cfg_index;
  logic [7:0]  cfg_wdata;

  // Shadow of the block: command table and registers
  op_t         op_mem   [MAX_COMMANDS];
  logic [63:0] opnd_mem [MAX_COMMANDS];
  logic [1:0]  size_r;
  logic [7:0]  count_r;

  result_exp_t pending_results[$];
  logic        pin_now;
  logic [63:0] pin_val;
  logic [63:0] last_cipher;
  int          gap_pct;
  int          sent;
  bit          dirty;
  int          mismatches;
  int          idle_cycles;

  reversible_value_transform_chain dut (.*);

  initial begin : clock_gen
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] width_mask(logic [1:0] sz);
    if (sz == SZ_QWORD) return ONES;
    return (64'd1 << (8 << sz)) - 64'd1;
  endfunction

  // Apply one command at the current size; undo runs the inverse direction
  function automatic logic [63:0] apply_command(op_t op, logic [63:0] k, logic [63:0] v,
                                                bit undo);
    int          bits;
    int          nb;
    int          amt;
    int          i;
    logic [63:0] m;
    logic [63:0] r;
    bits = 8 << size_r;
    nb   = 1 << size_r;
    m    = width_mask(size_r);
    if (undo) begin
      case (op)
        OP_ADD: op = OP_SUB;
        OP_SUB: op = OP_ADD;
        OP_ROL: op = OP_ROR;
        OP_ROR: op = OP_ROL;
        default: ;
      endcase
    end
    case (op)
      OP_ADD: r = v + k;
      OP_SUB: r = v - k;
      OP_XOR: r = v ^ k;
      OP_NOT: r = ~v;
      OP_NEG: r = 64'd0 - v;
      OP_BSWAP: begin
        // byte size leaves all 64 bits alone
        if (nb == 1) r = v;
        else begin
          r = '0;
          for (i = 0; i < nb; i++) r[8*(nb-1-i) +: 8] = v[8*i +: 8];
        end
      end
      default: begin
        amt = int'(k % 64'(bits));
        r   = v & m;
        if (amt != 0) begin
          if (op == OP_ROR) amt = bits - amt;
          r = ((r << amt) | (r >> (bits - amt))) & m;
        end
      end
    endcase
    return r;
  endfunction

  // Run a value through the active part of the table; counts past the depth saturate
  function automatic logic [63:0] transform_chain(logic [63:0] v, bit undo);
    int n;
    int i;
    n = (int'(count_r) > MAX_COMMANDS) ? MAX_COMMANDS : int'(count_r);
    if (!undo) begin
      for (i = 0; i < n; i++) v = apply_command(op_mem[i], opnd_mem[i], v, 1'b0);
    end else begin
      for (i = n - 1; i >= 0; i--) v = apply_command(op_mem[i], opnd_mem[i], v, 1'b1);
    end
    return v;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] edge_or_random();
    case ($urandom_range(0, 7))
      0: return 64'd0;
      1: return ONES;
      2: return TOP_BIT;
      default: return rand64();
    endcase
  endfunction

  // Track the block at every edge: registers, table, expected results, watchdog
  always @(posedge clk) begin : scoreboard
    result_exp_t e;
    bit          busy;
    busy = 1'b0;
    if (rst_n) begin
      if (cfg_we) begin
        busy = 1'b1;
        if (cfg_index == REG_SIZE) size_r = cfg_wdata[1:0];
        else count_r = cfg_wdata;
      end
      if (in_valid && in_ready) begin
        busy = 1'b1;
        case (in_kind)
          KIND_LOAD: begin
            op_mem[in_slot]   = op_t'(in_op_code);
            opnd_mem[in_slot] = in_operand & width_mask(size_r);
          end
          KIND_ENC, KIND_DEC: begin
            e.value        = transform_chain(in_data, in_kind == KIND_DEC);
            e.pinned       = pin_now;
            e.pinned_value = pin_val;
            if (in_kind == KIND_ENC) last_cipher = e.value;
            pending_results.push_back(e);
          end
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        busy = 1'b1;
        if (pending_results.size() == 0) begin
          $error("result beat with nothing pending: actual %h", out_result);
          mismatches++;
        end else begin
          e = pending_results.pop_front();
          if (out_result !== e.value) begin
            $error("result mismatch: expected %h, actual %h", e.value, out_result);
            mismatches++;
          end
          if (e.pinned && out_result !== e.pinned_value) begin
            $error("result mismatch: expected %h, actual %h", e.pinned_value, out_result);
            mismatches++;
          end
        end
      end
      if (busy) idle_cycles = 0;
      else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  // Result side: random stall bursts
  initial begin : result_sink
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Drive one beat, with an optional idle burst ahead of it; return once accepted
  task automatic send_beat(logic [1:0] kind, logic [6:0] slot, op_t op, logic [63:0] operand,
                           logic [63:0] data, logic pin, logic [63:0] want);
    @(negedge clk);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_slot    <= slot;
    in_op_code <= op;
    in_operand <= operand;
    in_data    <= data;
    pin_now     = pin;
    pin_val     = want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (kind != KIND_NONE) sent++;
    dirty = 1'b1;
  endtask

  // Drop valid, drain every pending result, then let the block go quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    dirty = 1'b0;
  endtask

  task automatic write_reg(logic idx, logic [7:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    int   r;
    int   j;
    int   batch;
    int   roll;
    row_t row;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_kind     = KIND_LOAD;
    in_slot     = '0;
    in_op_code  = OP_ADD;
    in_operand  = '0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_index   = REG_SIZE;
    cfg_wdata   = '0;
    size_r      = SZ_BYTE;
    count_r     = '0;
    pin_now     = 1'b0;
    pin_val     = '0;
    last_cipher = '0;
    gap_pct     = 5;
    sent        = 0;
    dirty       = 1'b0;
    mismatches  = 0;
    idle_cycles = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed script
    for (r = 0; r < NROWS; r++) begin
      row = SCRIPT[r];
      if (row.act == ROW_REG) begin
        if (dirty) settle();
        write_reg(row.reg_idx, row.data[7:0]);
      end else begin
        send_beat(row.kind, row.slot, row.op, row.operand, row.data, row.pin, row.want);
      end
    end

    // Fill the whole table so any count reads only written entries
    settle();
    write_reg(REG_SIZE, 8'($urandom_range(0, 3)));
    for (r = 0; r < MAX_COMMANDS; r++)
      send_beat(KIND_LOAD, 7'(r), op_t'(3'($urandom_range(0, 7))), edge_or_random(),
                rand64(), 1'b0, '0);

    // Random phases, each with fresh settings
    while (sent < ITEMS) begin
      settle();
      write_reg(REG_SIZE, 8'($urandom_range(0, 3)));
      case ($urandom_range(0, 5))
        0: write_reg(REG_COUNT, 8'd0);
        1: write_reg(REG_COUNT, 8'd1);
        2: write_reg(REG_COUNT, 8'(MAX_COMMANDS));
        3: write_reg(REG_COUNT, 8'($urandom_range(MAX_COMMANDS + 1, 255)));
        default: write_reg(REG_COUNT, 8'($urandom_range(2, MAX_COMMANDS - 1)));
      endcase
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 5;
        default: gap_pct = 20;
      endcase
      batch = $urandom_range(8, 30);
      for (j = 0; j < batch && sent < ITEMS; j++) begin
        // hold off all idling near the end of the run
        if (sent >= ITEMS - 60) gap_pct = 0;
        roll = $urandom_range(0, 99);
        if (roll < 25)
          send_beat(KIND_LOAD, 7'($urandom_range(0, 127)), op_t'(3'($urandom_range(0, 7))),
                    edge_or_random(), rand64(), 1'b0, '0);
        else if (roll < 30)
          send_beat(KIND_NONE, 7'($urandom_range(0, 127)), op_t'(3'($urandom_range(0, 7))),
                    rand64(), rand64(), 1'b0, '0);
        else if (roll < 65)
          send_beat(KIND_ENC, 7'($urandom_range(0, 127)), op_t'(3'($urandom_range(0, 7))),
                    rand64(), edge_or_random(), 1'b0, '0);
        else
          send_beat(KIND_DEC, 7'($urandom_range(0, 127)), op_t'(3'($urandom_range(0, 7))),
                    rand64(), $urandom_range(0, 1) ? last_cipher : edge_or_random(),
                    1'b0, '0);
      end
    end

    settle();
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
